// ----- rtl/core/mrp_pkg.sv -----
// ----------------------------------------------------------------------------
// mrp_pkg
// Shared types, codes and helper functions of the Modbus RTU response parser.
// ----------------------------------------------------------------------------
package mrp_pkg;

	localparam int unsigned FRAME_BYTES_MAX_DEF = 24;

	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_REQUEST_KIND      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_REGISTER = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_VALUE    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS     = 3'd4;

	localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'h01;
	localparam logic [15:0] TIMEOUT_TICKS_RST  = 16'd2000;
	localparam logic [15:0] CRC_INIT           = 16'hFFFF;
	localparam logic [15:0] CRC_POLY           = 16'hA001;

	typedef enum logic [1:0] {
		RK_WRITE_REG  = 2'd0,
		RK_READ_REG   = 2'd1,
		RK_MOTOR_CMD  = 2'd2,
		RK_MOTOR_READ = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		KIND_START = 2'd0,
		KIND_BYTE  = 2'd1,
		KIND_TICK  = 2'd2
	} in_kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_CRC      = 2'd1,
		ST_MISMATCH = 2'd2,
		ST_TIMEOUT  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_HUNT   = 2'd1,
		PH_GATHER = 2'd2
	} phase_t;

	// Control that every byte cell of the frame chain sees
	typedef struct packed {
		logic       strobe; // a frame byte is on the bus: advance the token
		logic       clear;  // drop all tokens (new transaction)
		logic [7:0] data;
	} cell_ctl_t;

	function automatic logic [4:0] frame_len(input req_kind_t k);
		logic [4:0] len;
		case (k)
			RK_WRITE_REG:  len = 5'd8;
			RK_READ_REG:   len = 5'd7;
			RK_MOTOR_CMD:  len = 5'd19;
			RK_MOTOR_READ: len = 5'd24;
			default:       len = 5'd24;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] func_code(input req_kind_t k);
		logic [7:0] fc;
		case (k)
			RK_WRITE_REG:  fc = 8'h06;
			RK_READ_REG:   fc = 8'h03;
			RK_MOTOR_CMD:  fc = 8'h64;
			RK_MOTOR_READ: fc = 8'h68;
			default:       fc = 8'h68;
		endcase
		return fc;
	endfunction

	// Reflected CRC-16 update over one byte, LSB first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ----- rtl/core/modbus_rtu_response_parser.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_response_parser
// Receive side of a Modbus RTU master: frame capture, checks, result output.
// ----------------------------------------------------------------------------
// The parser takes one input transfer per clock: a start item arms it, byte
// items feed the frame, tick items count silence. Each transfer is handled in
// the cycle it is accepted; a result (frame done or timeout) lands in the
// output register on the next edge, so throughput is one item per cycle.
// Input ready drops only while a result waits in the output register and
// the consumer holds out_ready low. After the address byte the frame bytes
// walk into a row of byte cells steered by a one-hot token; the CRC-16 is
// updated per byte, and the frame is judged on its last byte from the cells
// already filled. Configuration writes take effect on the next clock edge;
// write them between transactions.
// ----------------------------------------------------------------------------
module modbus_rtu_response_parser #(
	parameter int unsigned FRAME_BYTES_MAX = mrp_pkg::FRAME_BYTES_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration port
	input  logic                              cfg_we,
	input  logic [mrp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mrp_pkg::CFG_DATA_W-1:0]    cfg_data,
	// input channel
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        kind,
	input  logic [7:0]                        rx_byte,
	// result channel
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [31:0]                       register_value,
	output logic [7:0]                        operating_mode,
	output logic [31:0]                       shaft_pos,
	output logic [31:0]                       force_actual,
	output logic [15:0]                       power_draw,
	output logic [7:0]                        temperature,
	output logic [15:0]                       supply_voltage,
	output logic [15:0]                       error_flags
);
	import mrp_pkg::*;

	// ------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------
	req_kind_t   req_kind_q;
	logic [7:0]  dev_addr_q;
	logic [15:0] exp_reg_q;
	logic [15:0] exp_val_q;
	logic [15:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_kind_q <= RK_WRITE_REG;
			dev_addr_q <= DEVICE_ADDRESS_RST;
			exp_reg_q  <= '0;
			exp_val_q  <= '0;
			timeout_q  <= TIMEOUT_TICKS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_REQUEST_KIND:      req_kind_q <= req_kind_t'(cfg_data[1:0]);
				REG_DEVICE_ADDRESS:    dev_addr_q <= cfg_data[7:0];
				REG_EXPECTED_REGISTER: exp_reg_q  <= cfg_data;
				REG_EXPECTED_VALUE:    exp_val_q  <= cfg_data;
				REG_TIMEOUT_TICKS:     timeout_q  <= cfg_data;
				default: ; // unknown index: drop the write
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Input decode
	// ------------------------------------------------------------------
	phase_t      phase_q, phase_d;
	logic [4:0]  cnt_q;
	logic [15:0] crc_q;
	logic [15:0] silence_q;
	logic        out_valid_q;

	logic acc, is_start, is_byte, is_tick, armed, addr_hit;

	// Output register parts the two sides: take a new item whenever the
	// slot is empty or is being drained this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;
	assign is_start = acc && (kind == KIND_START);
	assign is_byte  = acc && (kind == KIND_BYTE);
	assign is_tick  = acc && (kind == KIND_TICK);
	assign armed    = (phase_q != PH_IDLE);
	assign addr_hit = (rx_byte == dev_addr_q);

	// Running CRC restarts at the address byte while hunting
	logic [15:0] crc_nxt;
	logic [4:0]  cnt_inc;
	logic        frame_done, timeout_hit, take_byte, first_byte;

	assign crc_nxt     = crc_feed((phase_q == PH_HUNT) ? CRC_INIT : crc_q, rx_byte);
	assign cnt_inc     = (cnt_q == 5'd31) ? cnt_q : cnt_q + 5'd1;
	assign first_byte  = is_byte && (phase_q == PH_HUNT) && addr_hit;
	assign take_byte   = first_byte || (is_byte && (phase_q == PH_GATHER));
	assign frame_done  = is_byte && (phase_q == PH_GATHER)
	                     && (cnt_inc >= frame_len(req_kind_q));
	assign timeout_hit = is_tick && armed && (silence_q >= timeout_q);

	// ------------------------------------------------------------------
	// Phase sequencer
	// ------------------------------------------------------------------
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE: begin
				if (is_start) phase_d = PH_HUNT;
			end
			PH_HUNT: begin
				if (is_start)        phase_d = PH_HUNT;
				else if (first_byte) phase_d = PH_GATHER;
				else if (timeout_hit) phase_d = PH_IDLE;
			end
			PH_GATHER: begin
				if (is_start)         phase_d = PH_HUNT;
				else if (frame_done)  phase_d = PH_IDLE;
				else if (timeout_hit) phase_d = PH_IDLE;
			end
			default: phase_d = PH_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	// ------------------------------------------------------------------
	// Byte counter, CRC and silence counter
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			crc_q     <= CRC_INIT;
			silence_q <= '0;
		end else if (is_start) begin
			cnt_q     <= '0;
			crc_q     <= CRC_INIT;
			silence_q <= '0;
		end else if (is_byte && armed) begin
			// any byte while armed clears silence, even a skipped one
			silence_q <= '0;
			if (first_byte) begin
				cnt_q <= 5'd1;
				crc_q <= crc_nxt;
			end else if (phase_q == PH_GATHER) begin
				cnt_q <= cnt_inc;
				crc_q <= crc_nxt;
			end
		end else if (is_tick && armed && !timeout_hit) begin
			silence_q <= silence_q + 16'd1;
		end
	end

	// ------------------------------------------------------------------
	// Frame store: chain of byte cells
	// ------------------------------------------------------------------
	cell_ctl_t                           chain_ctl;
	logic [FRAME_BYTES_MAX-1:0][7:0]     fb;

	assign chain_ctl.strobe = take_byte;
	assign chain_ctl.clear  = is_start;
	assign chain_ctl.data   = rx_byte;

	mrp_frame_chain #(
		.FRAME_BYTES_MAX (FRAME_BYTES_MAX)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (chain_ctl),
		.first  (first_byte),
		.bytes  (fb)
	);

	// ------------------------------------------------------------------
	// Result build: every field read sits below the last byte's index,
	// so the cells already hold it when the last byte arrives.
	// ------------------------------------------------------------------
	status_t     res_status;
	logic [31:0] res_regval, res_shaft, res_force;
	logic [7:0]  res_mode, res_temp;
	logic [15:0] res_power, res_volt, res_err;
	logic        bad;

	always_comb begin
		res_status = ST_OK;
		res_regval = '0;
		res_mode   = '0;
		res_shaft  = '0;
		res_force  = '0;
		res_power  = '0;
		res_temp   = '0;
		res_volt   = '0;
		res_err    = '0;
		bad        = (fb[1] != func_code(req_kind_q));
		if (req_kind_q == RK_WRITE_REG) begin
			if ({fb[2], fb[3]} != exp_reg_q || {fb[4], fb[5]} != exp_val_q) begin
				bad = 1'b1;
			end
		end
		if (timeout_hit) begin
			res_status = ST_TIMEOUT;
		end else if (bad) begin
			res_status = ST_MISMATCH;
		end else begin
			res_status = (crc_nxt != 16'h0000) ? ST_CRC : ST_OK;
			case (req_kind_q)
				RK_READ_REG: begin
					res_regval = {16'h0000, fb[3], fb[4]};
				end
				RK_MOTOR_CMD: begin
					res_shaft = {fb[2], fb[3], fb[4], fb[5]};
					res_force = {fb[6], fb[7], fb[8], fb[9]};
					res_power = {fb[10], fb[11]};
					res_temp  = fb[12];
					res_volt  = {fb[13], fb[14]};
					res_err   = {fb[15], fb[16]};
				end
				RK_MOTOR_READ: begin
					res_regval = {fb[2], fb[3], fb[4], fb[5]};
					res_mode   = fb[6];
					res_shaft  = {fb[7], fb[8], fb[9], fb[10]};
					res_force  = {fb[11], fb[12], fb[13], fb[14]};
					res_power  = {fb[15], fb[16]};
					res_temp   = fb[17];
					res_volt   = {fb[18], fb[19]};
					res_err    = {fb[20], fb[21]};
				end
				default: ; // write echo: status only
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	logic        res_load;
	status_t     status_q;
	logic [31:0] regval_q, shaft_q, force_q;
	logic [7:0]  mode_q, temp_q;
	logic [15:0] power_q, volt_q, err_q;

	assign res_load = frame_done || timeout_hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			status_q <= res_status;
			regval_q <= res_regval;
			mode_q   <= res_mode;
			shaft_q  <= res_shaft;
			force_q  <= res_force;
			power_q  <= res_power;
			temp_q   <= res_temp;
			volt_q   <= res_volt;
			err_q    <= res_err;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign register_value = regval_q;
	assign operating_mode = mode_q;
	assign shaft_pos      = shaft_q;
	assign force_actual   = force_q;
	assign power_draw     = power_q;
	assign temperature    = temp_q;
	assign supply_voltage = volt_q;
	assign error_flags    = err_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_res_from_item: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(in_valid && in_ready))
		else $error("result appeared without an accepted item");

	a_res_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |=> (phase_q == PH_IDLE))
		else $error("parser still armed after emitting a result");

	a_gather_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_GATHER) |-> (cnt_q != 5'd0))
		else $error("gathering with an empty byte count");

	a_idle_no_res: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> !res_load)
		else $error("result produced while idle");

endmodule

// ----- rtl/core/mrp_byte_cell.sv -----
// ----------------------------------------------------------------------------
// mrp_byte_cell
// One byte slot of the frame chain: holds a byte and the write token.
// ----------------------------------------------------------------------------
module mrp_byte_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  mrp_pkg::cell_ctl_t ctl,
	input  logic               sel_in,
	output logic               sel_out,
	output logic [7:0]         data
);
	import mrp_pkg::*;

	logic       tok_q;
	logic [7:0] data_q;

	// Token moves one cell to the right on every frame byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else if (ctl.clear) begin
			tok_q <= 1'b0;
		end else if (ctl.strobe) begin
			tok_q <= sel_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.strobe && sel_in) begin
			data_q <= ctl.data;
		end
	end

	assign sel_out = tok_q;
	assign data    = data_q;

endmodule

// ----- rtl/core/mrp_frame_chain.sv -----
// ----------------------------------------------------------------------------
// mrp_frame_chain
// Row of byte cells; a token walks the row and marks the slot to write next.
// ----------------------------------------------------------------------------
module mrp_frame_chain #(
	parameter int unsigned FRAME_BYTES_MAX = mrp_pkg::FRAME_BYTES_MAX_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mrp_pkg::cell_ctl_t                ctl,
	input  logic                              first,
	output logic [FRAME_BYTES_MAX-1:0][7:0]   bytes
);
	import mrp_pkg::*;

	logic [FRAME_BYTES_MAX:0] sel;

	// Address byte enters cell 0 directly
	assign sel[0] = first;

	for (genvar i = 0; i < FRAME_BYTES_MAX; i++) begin : g_cell
		mrp_byte_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl),
			.sel_in  (sel[i]),
			.sel_out (sel[i+1]),
			.data    (bytes[i])
		);
	end

	logic [FRAME_BYTES_MAX-1:0] toks;
	assign toks = sel[FRAME_BYTES_MAX:1];

	a_tok_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(toks))
		else $error("more than one write token in the frame chain");

	a_tok_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.clear |=> (toks == '0))
		else $error("tokens survived a clear");

	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.strobe && !ctl.clear |=> $stable(toks))
		else $error("token moved without a frame byte");

endmodule

// ----- test/modbus_rtu_response_parser_test.sv -----
// ----------------------------------------------------------------------------
// modbus_rtu_response_parser_test
// Self-checking bench for the Modbus RTU response parser. A driver feeds start,
// byte and tick events from a queue and a monitor checks every result against
// a predictor of the parser that runs on each accepted input transfer.
// ----------------------------------------------------------------------------
module modbus_rtu_response_parser_test;
	import mrp_pkg::*;

	// Input kind the parser must drop without effect
	localparam logic [1:0] KIND_IGNORED = 2'd3;

	localparam int unsigned FRAME_DEPTH = 24;
	localparam logic [15:0] CRC16_SEED  = 16'hFFFF;
	localparam logic [15:0] CRC16_POLY  = 16'hA001;

	// Function codes the slave answers with, per request kind
	localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
	localparam logic [7:0] FC_READ_HOLDING = 8'h03;
	localparam logic [7:0] FC_MOTOR_CMD    = 8'h64;
	localparam logic [7:0] FC_MOTOR_READ   = 8'h68;

	localparam int unsigned RANDOM_ITEMS = 1150;
	localparam int unsigned PHASE_ITEMS  = 90;
	localparam int unsigned HOLD_AFTER   = 12;      // result count that starts the long stall
	localparam int unsigned LONG_HOLD    = 300;     // cycles of the long stall
	localparam int unsigned CYCLE_LIMIT  = 400000;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} line_event_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] register_value;
		logic [7:0]  operating_mode;
		logic [31:0] shaft_pos;
		logic [31:0] force_actual;
		logic [15:0] power_draw;
		logic [7:0]  temperature;
		logic [15:0] supply_voltage;
		logic [15:0] error_flags;
	} reply_t;

	typedef enum logic [2:0] {
		FL_GOOD,
		FL_BAD_CRC,
		FL_BAD_FC,
		FL_BAD_ECHO,
		FL_CUT
	} reply_flavor_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] kind     = KIND_START;
	logic [7:0] rx_byte  = 8'h00;

	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [31:0] register_value;
	logic [7:0]  operating_mode;
	logic [31:0] shaft_pos;
	logic [31:0] force_actual;
	logic [15:0] power_draw;
	logic [7:0]  temperature;
	logic [15:0] supply_voltage;
	logic [15:0] error_flags;

	// Stimulus and scoreboard stores
	line_event_t line_events[$];
	reply_t      awaited_replies[$];
	int unsigned events_queued = 0;
	int unsigned mismatches    = 0;
	int unsigned cycle_count   = 0;

	// Mirror of the configuration registers
	req_kind_t   c_kind    = RK_WRITE_REG;
	logic [7:0]  c_addr    = 8'h01;
	logic [15:0] c_reg     = 16'h0000;
	logic [15:0] c_val     = 16'h0000;
	logic [15:0] c_timeout = 16'd2000;

	// Predicted parser state
	phase_t      p_phase   = PH_IDLE;
	logic [7:0]  p_frame [0:FRAME_DEPTH-1];
	logic [4:0]  p_count   = '0;
	logic [15:0] p_crc     = CRC16_SEED;
	logic [15:0] p_silence = '0;

	// Idling state of both sides
	int unsigned tx_gap    = 0;
	logic        tx_steady = 1'b0;
	int unsigned rx_hold   = 0;
	logic        rx_steady = 1'b0;
	int unsigned replies_seen = 0;

	modbus_rtu_response_parser DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.register_value (register_value),
		.operating_mode (operating_mode),
		.shaft_pos      (shaft_pos),
		.force_actual   (force_actual),
		.power_draw     (power_draw),
		.temperature    (temperature),
		.supply_voltage (supply_voltage),
		.error_flags    (error_flags)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	function automatic logic [4:0] reply_length(input req_kind_t rk);
		case (rk)
			RK_WRITE_REG:  return 5'd8;
			RK_READ_REG:   return 5'd7;
			RK_MOTOR_CMD:  return 5'd19;
			default:       return 5'd24;
		endcase
	endfunction

	function automatic logic [7:0] reply_code(input req_kind_t rk);
		case (rk)
			RK_WRITE_REG:  return FC_WRITE_SINGLE;
			RK_READ_REG:   return FC_READ_HOLDING;
			RK_MOTOR_CMD:  return FC_MOTOR_CMD;
			default:       return FC_MOTOR_READ;
		endcase
	endfunction

	// Modbus CRC-16, reflected, one byte shifted in LSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
		logic [15:0] r;
		int i;
		r = acc ^ {8'h00, b};
		for (i = 0; i < 8; i++) begin
			if (r[0])
				r = {1'b0, r[15:1]} ^ CRC16_POLY;
			else
				r = {1'b0, r[15:1]};
		end
		return r;
	endfunction

	// Advance the predicted parser by one accepted input transfer and queue
	// the result it causes, if any.
	task automatic follow_line_event(input logic [1:0] ev_kind, input logic [7:0] b);
		reply_t r;
		logic   bad;
		r = '0;
		case (ev_kind)
			KIND_START: begin
				// a start always rearms, dropping any partial frame
				p_phase   = PH_HUNT;
				p_count   = '0;
				p_crc     = CRC16_SEED;
				p_silence = '0;
			end
			KIND_BYTE: begin
				if (p_phase != PH_IDLE) begin
					p_silence = '0;
					if (p_phase == PH_HUNT) begin
						// skip bytes until the slave address shows up
						if (b == c_addr) begin
							p_frame[0] = b;
							p_count    = 5'd1;
							p_crc      = crc16_byte(CRC16_SEED, b);
							p_phase    = PH_GATHER;
						end
					end else begin
						if (p_count < FRAME_DEPTH)
							p_frame[p_count] = b;
						if (p_count != 5'd31)
							p_count = p_count + 5'd1;
						p_crc = crc16_byte(p_crc, b);
						if (p_count >= reply_length(c_kind)) begin
							// judge the frame: codes and echo first, then CRC residue
							bad = (p_frame[1] != reply_code(c_kind));
							if (c_kind == RK_WRITE_REG &&
							    ({p_frame[2], p_frame[3]} != c_reg ||
							     {p_frame[4], p_frame[5]} != c_val))
								bad = 1'b1;
							if (bad) begin
								r.status = ST_MISMATCH;
							end else begin
								r.status = (p_crc != 16'h0000) ? ST_CRC : ST_OK;
								case (c_kind)
									RK_READ_REG: begin
										r.register_value = {16'h0000, p_frame[3], p_frame[4]};
									end
									RK_MOTOR_CMD: begin
										r.shaft_pos      = {p_frame[2], p_frame[3],
										                    p_frame[4], p_frame[5]};
										r.force_actual   = {p_frame[6], p_frame[7],
										                    p_frame[8], p_frame[9]};
										r.power_draw     = {p_frame[10], p_frame[11]};
										r.temperature    = p_frame[12];
										r.supply_voltage = {p_frame[13], p_frame[14]};
										r.error_flags    = {p_frame[15], p_frame[16]};
									end
									RK_MOTOR_READ: begin
										r.register_value = {p_frame[2], p_frame[3],
										                    p_frame[4], p_frame[5]};
										r.operating_mode = p_frame[6];
										r.shaft_pos      = {p_frame[7], p_frame[8],
										                    p_frame[9], p_frame[10]};
										r.force_actual   = {p_frame[11], p_frame[12],
										                    p_frame[13], p_frame[14]};
										r.power_draw     = {p_frame[15], p_frame[16]};
										r.temperature    = p_frame[17];
										r.supply_voltage = {p_frame[18], p_frame[19]};
										r.error_flags    = {p_frame[20], p_frame[21]};
									end
									default: ;
								endcase
							end
							p_phase = PH_IDLE;
							awaited_replies.push_back(r);
						end
					end
				end
			end
			KIND_TICK: begin
				if (p_phase != PH_IDLE) begin
					// timeout lands on the tick after timeout_ticks silent ticks
					if (p_silence >= c_timeout) begin
						p_phase  = PH_IDLE;
						r.status = ST_TIMEOUT;
						awaited_replies.push_back(r);
					end else begin
						p_silence = p_silence + 16'd1;
					end
				end
			end
			default: ;
		endcase
	endtask

	// ------------------------------------------------------------------
	// Driver: present queued events, one transfer per handshake
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : event_driver
		line_event_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind     <= KIND_START;
			rx_byte  <= 8'h00;
			tx_gap    = 0;
		end else begin
			// predict on the transfer that completes at this edge
			if (in_valid && in_ready)
				follow_line_event(kind, rx_byte);
			if (!in_valid || in_ready) begin
				if (tx_gap != 0) begin
					// hold off the next event
					tx_gap   = tx_gap - 1;
					in_valid <= 1'b0;
				end else if (line_events.size() != 0) begin
					nxt = line_events.pop_front();
					in_valid <= 1'b1;
					kind     <= nxt.kind;
					rx_byte  <= nxt.data;
					// draw the gap after this event; switch between bursts and gaps now and then
					if ($urandom_range(0, 29) == 0)
						tx_steady = !tx_steady;
					tx_gap = tx_steady ? 0 : $urandom_range(0, 16);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: check each accepted result and pace out_ready
	// ------------------------------------------------------------------

	task automatic check_field(input string name, input logic [31:0] want,
	                           input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : result_monitor
		reply_t      want;
		int unsigned pause;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_hold    = 0;
		end else if (out_valid && out_ready) begin
			if (awaited_replies.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual status %0h",
				         $time, status);
				mismatches++;
			end else begin
				want = awaited_replies.pop_front();
				check_field("status",         32'(want.status),         32'(status));
				check_field("register_value", want.register_value,      register_value);
				check_field("operating_mode", 32'(want.operating_mode), 32'(operating_mode));
				check_field("shaft_pos",      want.shaft_pos,           shaft_pos);
				check_field("force_actual",   want.force_actual,        force_actual);
				check_field("power_draw",     32'(want.power_draw),     32'(power_draw));
				check_field("temperature",    32'(want.temperature),    32'(temperature));
				check_field("supply_voltage", 32'(want.supply_voltage), 32'(supply_voltage));
				check_field("error_flags",    32'(want.error_flags),    32'(error_flags));
			end
			replies_seen++;
			// once, stall long enough for the parser to back up into its input
			if ($urandom_range(0, 29) == 0)
				rx_steady = !rx_steady;
			if (replies_seen == HOLD_AFTER)
				pause = LONG_HOLD;
			else
				pause = rx_steady ? 0 : $urandom_range(0, 16);
			if (pause != 0) begin
				out_ready <= 1'b0;
				rx_hold    = pause;
			end
		end else if (!out_ready) begin
			if (rx_hold <= 1) begin
				out_ready <= 1'b1;
				rx_hold    = 0;
			end else begin
				rx_hold = rx_hold - 1;
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic push_item(input logic [1:0] ev_kind, input logic [7:0] d, input bit counted);
		line_event_t e;
		e.kind = ev_kind;
		e.data = d;
		line_events.push_back(e);
		if (counted)
			events_queued++;
	endtask

	// Occasionally drop in a few ticks between bytes, never enough to time out
	task automatic queue_gap_ticks();
		int unsigned cap;
		if ($urandom_range(0, 5) == 0) begin
			cap = (c_timeout > 3) ? 3 : c_timeout;
			repeat ($urandom_range(0, cap))
				push_item(KIND_TICK, 8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	// Build one slave reply for the current request kind, spoiled as asked
	task automatic queue_reply(input reply_flavor_t fl);
		logic [7:0]  fr [0:FRAME_DEPTH-1];
		logic [15:0] acc;
		int          n;
		int          cut;
		int          i;
		n = reply_length(c_kind);
		fr[0] = c_addr;
		fr[1] = reply_code(c_kind);
		for (i = 2; i < n; i++)
			fr[i] = 8'($urandom_range(0, 255));
		if (c_kind == RK_WRITE_REG && fl != FL_BAD_ECHO) begin
			fr[2] = c_reg[15:8];
			fr[3] = c_reg[7:0];
			fr[4] = c_val[15:8];
			fr[5] = c_val[7:0];
		end
		if (c_kind == RK_READ_REG)
			fr[2] = 8'd2;
		if (fl == FL_BAD_FC)
			fr[1] = reply_code(c_kind) ^ 8'($urandom_range(1, 255));
		acc = CRC16_SEED;
		for (i = 0; i < n - 2; i++)
			acc = crc16_byte(acc, fr[i]);
		fr[n-2] = acc[7:0];
		fr[n-1] = acc[15:8];
		if (fl == FL_BAD_CRC) begin
			i = $urandom_range(2, n - 1);
			fr[i] = fr[i] ^ (8'h01 << $urandom_range(0, 7));
		end
		cut = (fl == FL_CUT) ? $urandom_range(0, n - 1) : n;
		for (i = 0; i < cut; i++) begin
			push_item(KIND_BYTE, fr[i], 1'b1);
			if (i + 1 < n)
				queue_gap_ticks();
		end
		// let a cut frame run into the timeout when that is short enough
		if (fl == FL_CUT && c_timeout <= 16)
			repeat (c_timeout + 1)
				push_item(KIND_TICK, 8'($urandom_range(0, 255)), 1'b1);
	endtask

	// One transaction: start, line noise ahead of the address, a reply, and
	// sometimes stray events after it. A tidy one always ends in idle.
	task automatic queue_exchange(input bit tidy);
		reply_flavor_t fl;
		int unsigned   roll;
		logic [7:0]    d;
		push_item(KIND_START, 8'($urandom_range(0, 255)), 1'b1);
		repeat ($urandom_range(0, 2)) begin
			d = 8'($urandom_range(0, 255));
			if (d == c_addr)
				d = d ^ 8'h80;
			push_item(KIND_BYTE, d, 1'b1);
			queue_gap_ticks();
		end
		roll = $urandom_range(0, 19);
		if (tidy || roll < 11)
			fl = FL_GOOD;
		else if (roll < 13)
			fl = FL_BAD_CRC;
		else if (roll < 15)
			fl = FL_BAD_FC;
		else if (roll < 17)
			fl = FL_BAD_ECHO;
		else
			fl = FL_CUT;
		queue_reply(fl);
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 4)) begin
				case ($urandom_range(0, 2))
					0:       push_item(KIND_BYTE,    8'($urandom_range(0, 255)), 1'b0);
					1:       push_item(KIND_TICK,    8'($urandom_range(0, 255)), 1'b0);
					default: push_item(KIND_IGNORED, 8'($urandom_range(0, 255)), 1'b0);
				endcase
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		case (idx)
			REG_REQUEST_KIND:      c_kind    = req_kind_t'(data[1:0]);
			REG_DEVICE_ADDRESS:    c_addr    = data[7:0];
			REG_EXPECTED_REGISTER: c_reg     = data;
			REG_EXPECTED_VALUE:    c_val     = data;
			REG_TIMEOUT_TICKS:     c_timeout = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every event is out and every result is in, then let the
	// last event's work drain through the pipeline
	task automatic settle();
		while (!(line_events.size() == 0 && !in_valid && awaited_replies.size() == 0))
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		int unsigned p;
		int unsigned phase_end;
		logic [15:0] v;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part on the reset settings (write echo, address 1):
		// events while idle, a dropped kind, address hunting, restart mid-frame,
		// a clean echo and one with a wrong function code.
		push_item(KIND_BYTE,    8'h55, 1'b1);
		push_item(KIND_TICK,    8'hAA, 1'b1);
		push_item(KIND_IGNORED, 8'hFF, 1'b1);
		push_item(KIND_START,   8'h00, 1'b1);
		push_item(KIND_BYTE,    8'h00, 1'b1);
		push_item(KIND_TICK,    8'h00, 1'b1);
		push_item(KIND_BYTE,    8'h01, 1'b1);
		push_item(KIND_START,   8'hFF, 1'b1);
		queue_reply(FL_GOOD);
		push_item(KIND_START,   8'h00, 1'b1);
		queue_reply(FL_BAD_FC);
		settle();

		// Random part: walk through request kinds and register settings,
		// extremes included; each phase ends idle so the next write is safe.
		events_queued = 0;
		p = 0;
		while (events_queued < RANDOM_ITEMS) begin
			write_reg(REG_REQUEST_KIND, 16'(p % 4));
			case (p % 5)
				1:       write_reg(REG_DEVICE_ADDRESS, 16'h0000);
				2:       write_reg(REG_DEVICE_ADDRESS, 16'h00FF);
				default: write_reg(REG_DEVICE_ADDRESS, 16'($urandom_range(0, 255)));
			endcase
			v = 16'($urandom_range(0, 65535));
			case (p % 3)
				0: begin
					write_reg(REG_EXPECTED_REGISTER, 16'h0000);
					write_reg(REG_EXPECTED_VALUE,    16'hFFFF);
				end
				1: begin
					write_reg(REG_EXPECTED_REGISTER, 16'hFFFF);
					write_reg(REG_EXPECTED_VALUE,    16'h0000);
				end
				default: begin
					write_reg(REG_EXPECTED_REGISTER, v);
					write_reg(REG_EXPECTED_VALUE,    16'($urandom_range(0, 65535)));
				end
			endcase
			case (p % 6)
				0:       write_reg(REG_TIMEOUT_TICKS, 16'd0);
				1:       write_reg(REG_TIMEOUT_TICKS, 16'd1);
				2:       write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
				3:       write_reg(REG_TIMEOUT_TICKS, 16'd2000);
				default: write_reg(REG_TIMEOUT_TICKS, 16'($urandom_range(2, 12)));
			endcase
			@(negedge clk);
			phase_end = events_queued + PHASE_ITEMS;
			while (events_queued < phase_end)
				queue_exchange(1'b0);
			queue_exchange(1'b1);
			settle();
			p++;
		end

		// settle() already drained the last phase
		if (mismatches == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
